>>> design/bmsfp_pkg.sv
// shared types and constants of the frame parser with cell statistics
package bmsfp_pkg;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 5;
  localparam int SUM_W  = 20;
  localparam int MV_W   = 16;

  localparam logic [7:0]  SYNC0_BYTE   = 8'hA5;
  localparam logic [7:0]  SYNC1_BYTE   = 8'h5A;
  localparam logic [7:0]  CMD_READ     = 8'h82;
  localparam logic [15:0] SUB_CELLS    = 16'h1100;
  localparam logic [15:0] SUB_PACK     = 16'h1000;
  localparam logic [7:0]  MIN_LEN      = 8'd3;
  localparam logic [7:0]  PACK_MIN_LEN = 8'd6;
  localparam logic [7:0]  CUR_MIN_LEN  = 8'd17;
  localparam logic [7:0]  SOC_MIN_LEN  = 8'd26;

  localparam logic [7:0] POS_CMD     = 8'd0;
  localparam logic [7:0] POS_SUB_HI  = 8'd1;
  localparam logic [7:0] POS_SUB_LO  = 8'd2;
  localparam logic [7:0] POS_TOT_HI  = 8'd3;
  localparam logic [7:0] POS_TOT_LO  = 8'd4;
  localparam logic [7:0] POS_CUR_HI  = 8'd15;
  localparam logic [7:0] POS_CUR_LO  = 8'd16;
  localparam logic [7:0] POS_SOC     = 8'd25;

  localparam logic [15:0] CELL_LOW_RST  = 16'd1000;
  localparam logic [15:0] CELL_HIGH_RST = 16'd5000;
  localparam logic [4:0]  MIN_GOOD_RST  = 5'd12;

  typedef enum logic [1:0] {
    REG_CELL_LOW  = 2'd0,
    REG_CELL_HIGH = 2'd1,
    REG_MIN_GOOD  = 2'd2,
    REG_NONE      = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    KIND_UNKNOWN = 2'd0,
    KIND_CELLS   = 2'd1,
    KIND_PACK    = 2'd2
  } frame_kind_t;

  typedef enum logic [1:0] {
    PH_SYNC0 = 2'd0,
    PH_SYNC1 = 2'd1,
    PH_LEN   = 2'd2,
    PH_BODY  = 2'd3
  } parse_phase_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_FIN  = 2'd1,
    ST_DIV  = 2'd2,
    ST_PUB  = 2'd3
  } seq_state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctrl_t;

endpackage

>>> design/bmsfp_div.sv
// iterative restoring divider, one quotient bit per cycle, for the cell average
module bmsfp_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [bmsfp_pkg::SUM_W-1:0] dividend,
  input  logic [bmsfp_pkg::CNT_W-1:0] divisor,
  output logic                       busy,
  output logic [bmsfp_pkg::SUM_W-1:0] quotient
);
  import bmsfp_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dvs;
  logic [SUM_W-1:0]  quo;
  logic [STEP_W-1:0] step;
  logic [CNT_W:0]    trial;
  logic              fits;

  assign trial    = {rem, quo[SUM_W-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + STEP_W'(1);
      if (step == LAST_STEP) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= CNT_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[CNT_W-1:0];
      end
      quo <= {quo[SUM_W-2:0], fits};
    end
  end

endmodule

>>> design/bms_frame_parser_cell_stats.sv
// top level: byte parser, cell statistics and published record
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_stall   | byte_in
//  out     | output    | out_valid / out_stall | frame_kind .. state_of_charge
//  cfg     | input     | apb psel / penable    | paddr, pwdata, prdata
//
// a byte that does not close a frame is accepted whenever the sequencer is idle
// a frame-closing byte passes the sequencer through finish and publish; when cell
// statistics are published, the 20-step divider that forms the average runs between them
// bytes stall while a result waits; the sequencer holds at publish
// until the output register is free
// rst is synchronous; it restores the register defaults and clears the record
module bms_frame_parser_cell_stats #(
  parameter int MAX_CELL_COUNT     = 24,
  parameter int FRAME_BUFFER_BYTES = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  byte_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  frame_kind,
  output logic                        data_valid,
  output logic [4:0]                  cell_count,
  output logic [15:0]                 cell_min_mv,
  output logic [15:0]                 cell_max_mv,
  output logic [15:0]                 cell_avg_mv,
  output logic [15:0]                 cell_delta_mv,
  output logic [19:0]                 pack_total_mv,
  output logic signed [19:0]          pack_current_ma,
  output logic [7:0]                  state_of_charge,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bmsfp_pkg::ADDR_W-1:0] paddr,
  input  logic [bmsfp_pkg::DATA_W-1:0] pwdata,
  output logic [bmsfp_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import bmsfp_pkg::*;

  localparam logic [8:0] MAX_LEN   = 9'(FRAME_BUFFER_BYTES - 3);
  localparam logic [8:0] CELL_LIMIT = 9'(4 + 2 * MAX_CELL_COUNT);

  // configuration
  logic [15:0]      cell_low;
  logic [15:0]      cell_high;
  logic [CNT_W-1:0] min_good;
  reg_index_t       reg_sel;
  logic             cfg_write;

  // parser state
  parse_phase_t     phase;
  logic [7:0]       body_length;
  logic [7:0]       body_position;
  logic [7:0]       command_byte;
  logic [15:0]      sub_command;
  logic [7:0]       high_byte_hold;
  logic [SUM_W-1:0] running_sum;
  logic [CNT_W-1:0] running_good;
  logic [15:0]      running_min;
  logic [15:0]      running_max;
  logic [15:0]      scratch_total;
  logic [15:0]      scratch_current;
  logic [7:0]       scratch_soc;

  // sequencer
  seq_state_t       state;
  seq_state_t       state_next;
  logic             div_start;
  logic             div_busy;
  logic             pub_en;
  logic             in_accept;
  logic             frame_end;
  logic             out_free;
  frame_kind_t      kind;
  logic [CNT_W-1:0] need;
  logic             cells_ok;
  logic [SUM_W-1:0] quotient;

  // per-byte datapath
  logic [15:0]      mv;
  logic             cell_slot;
  logic             cell_good;
  logic [SUM_W:0]   sum_wide;
  logic [8:0]       pos_inc;
  logic [SUM_W-1:0] total_x10;
  logic [SUM_W-1:0] cur_ext;
  logic [SUM_W-1:0] cur_x10;

  assign pready    = 1'b1;
  assign reg_sel   = reg_index_t'(paddr[ADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_low  <= CELL_LOW_RST;
      cell_high <= CELL_HIGH_RST;
      min_good  <= MIN_GOOD_RST;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_CELL_LOW:  cell_low  <= pwdata[15:0];
        REG_CELL_HIGH: cell_high <= pwdata[15:0];
        REG_MIN_GOOD:  min_good  <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CELL_LOW:  prdata = {16'd0, cell_low};
      REG_CELL_HIGH: prdata = {16'd0, cell_high};
      REG_MIN_GOOD:  prdata = {{(DATA_W - CNT_W){1'b0}}, min_good};
      default:       prdata = '0;
    endcase
  end

  assign in_accept = in_valid && !in_stall;
  assign pos_inc   = {1'b0, body_position} + 9'd1;
  assign frame_end = (phase == PH_BODY) && (pos_inc >= {1'b0, body_length});

  always_comb begin
    if (command_byte != CMD_READ) begin
      kind = KIND_UNKNOWN;
    end else if (sub_command == SUB_CELLS) begin
      kind = KIND_CELLS;
    end else if (sub_command == SUB_PACK) begin
      kind = KIND_PACK;
    end else begin
      kind = KIND_UNKNOWN;
    end
  end

  assign mv        = {high_byte_hold, byte_in};
  assign cell_slot = (body_position >= POS_TOT_LO) && !body_position[0]
                     && (kind == KIND_CELLS) && ({1'b0, body_position} < CELL_LIMIT);
  assign cell_good = cell_slot && (mv > cell_low) && (mv < cell_high);
  assign sum_wide  = {1'b0, running_sum} + (SUM_W + 1)'(mv);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SYNC0;
      body_length <= '0;
    end else if (in_accept) begin
      unique case (phase)
        PH_SYNC0: begin
          if (byte_in == SYNC0_BYTE) begin
            phase <= PH_SYNC1;
          end
        end
        PH_SYNC1: begin
          if (byte_in == SYNC1_BYTE) begin
            phase <= PH_LEN;
          end else if (byte_in != SYNC0_BYTE) begin
            phase <= PH_SYNC0;
          end
        end
        PH_LEN: begin
          body_length <= byte_in;
          if (byte_in < MIN_LEN || {1'b0, byte_in} > MAX_LEN) begin
            phase <= PH_SYNC0;
          end else begin
            phase <= PH_BODY;
          end
        end
        PH_BODY: begin
          if (frame_end) begin
            phase <= PH_SYNC0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && phase == PH_LEN) begin
      body_position   <= '0;
      command_byte    <= '0;
      sub_command     <= '0;
      high_byte_hold  <= '0;
      running_sum     <= '0;
      running_good    <= '0;
      running_min     <= '1;
      running_max     <= '0;
      scratch_total   <= '0;
      scratch_current <= '0;
      scratch_soc     <= '0;
    end else if (in_accept && phase == PH_BODY) begin
      body_position <= pos_inc[7:0];
      unique case (body_position)
        POS_CMD:    command_byte          <= byte_in;
        POS_SUB_HI: sub_command[15:8]     <= byte_in;
        POS_SUB_LO: sub_command[7:0]      <= byte_in;
        POS_TOT_HI: scratch_total[15:8]   <= byte_in;
        POS_TOT_LO: scratch_total[7:0]    <= byte_in;
        POS_CUR_HI: scratch_current[15:8] <= byte_in;
        POS_CUR_LO: scratch_current[7:0]  <= byte_in;
        POS_SOC:    scratch_soc           <= byte_in;
        default: ;
      endcase
      if (body_position >= POS_TOT_HI && body_position[0]) begin
        high_byte_hold <= byte_in;
      end
      if (cell_good) begin
        running_sum  <= sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
        running_good <= running_good + CNT_W'(1);
        if (mv < running_min) begin
          running_min <= mv;
        end
        if (mv > running_max) begin
          running_max <= mv;
        end
      end
    end
  end

  // frame-end sequencer
  assign need     = (min_good == '0) ? CNT_W'(1) : min_good;
  assign cells_ok = running_good >= need;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept && frame_end) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (kind == KIND_CELLS && cells_ok) begin
          state_next = ST_DIV;
        end else begin
          state_next = ST_PUB;
        end
      end
      ST_DIV: begin
        if (!div_busy) begin
          state_next = ST_PUB;
        end
      end
      ST_PUB: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != ST_IDLE);
    div_start = (state == ST_FIN) && (kind == KIND_CELLS) && cells_ok;
    pub_en    = (state == ST_PUB) && out_free;
  end

  bmsfp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (running_sum),
    .divisor  (running_good),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign total_x10 = ({4'd0, scratch_total} << 3) + ({4'd0, scratch_total} << 1);
  assign cur_ext   = {{(SUM_W - 16){scratch_current[15]}}, scratch_current};
  assign cur_x10   = (cur_ext << 3) + (cur_ext << 1);

  // published record doubles as the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      frame_kind      <= KIND_UNKNOWN;
      data_valid      <= 1'b0;
      cell_count      <= '0;
      cell_min_mv     <= '0;
      cell_max_mv     <= '0;
      cell_avg_mv     <= '0;
      cell_delta_mv   <= '0;
      pack_total_mv   <= '0;
      pack_current_ma <= '0;
      state_of_charge <= '0;
    end else if (pub_en) begin
      out_valid  <= 1'b1;
      frame_kind <= kind;
      if (kind == KIND_CELLS && cells_ok) begin
        data_valid    <= 1'b1;
        cell_count    <= running_good;
        cell_min_mv   <= running_min;
        cell_max_mv   <= running_max;
        cell_avg_mv   <= quotient[15:0];
        cell_delta_mv <= running_max - running_min;
        pack_total_mv <= running_sum;
      end else if (kind == KIND_PACK && body_length >= PACK_MIN_LEN) begin
        if (pack_total_mv == '0) begin
          pack_total_mv <= total_x10;
        end
        if (body_length >= CUR_MIN_LEN) begin
          pack_current_ma <= cur_x10;
        end
        if (body_length >= SOC_MIN_LEN) begin
          state_of_charge <= scratch_soc;
        end
      end
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

>>> design/bmsfp_checker.sv
// port-level checks of the frame parser, bound to the top level
module bmsfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  frame_kind,
  input logic        data_valid,
  input logic [4:0]  cell_count,
  input logic [15:0] cell_min_mv,
  input logic [15:0] cell_max_mv
);
  import bmsfp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(frame_kind))
    else $error("stalled transaction changed");

  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> frame_kind <= 2'(KIND_PACK))
    else $error("undefined frame kind");

  a_valid_sticky: assert property (@(posedge clk) disable iff (rst)
    data_valid |=> data_valid)
    else $error("data_valid dropped");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    data_valid |-> cell_count != 5'd0)
    else $error("published stats without cells");

  a_min_max: assert property (@(posedge clk) disable iff (rst)
    data_valid |-> cell_max_mv >= cell_min_mv)
    else $error("cell max below cell min");

endmodule

bind bms_frame_parser_cell_stats bmsfp_checker u_bmsfp_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .frame_kind  (frame_kind),
  .data_valid  (data_valid),
  .cell_count  (cell_count),
  .cell_min_mv (cell_min_mv),
  .cell_max_mv (cell_max_mv)
);

>>> sim/bms_frame_parser_cell_stats_tb.sv
// testbench for the frame parser with cell statistics: directed and random byte streams, predicted and checked
`timescale 1ns / 1ps

module bms_frame_parser_cell_stats_tb;
  import bmsfp_pkg::*;

  localparam int CELL_SLOTS    = 24;
  localparam int FRAME_BYTES   = 256;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 200000;

  typedef logic [7:0] byte_list_t[$];

  typedef struct packed {
    frame_kind_t kind;
    logic        valid;
    logic [4:0]  count;
    logic [15:0] min_mv;
    logic [15:0] max_mv;
    logic [15:0] avg_mv;
    logic [15:0] spread_mv;
    logic [19:0] total_mv;
    logic [19:0] current_ma;
    logic [7:0]  soc;
  } frame_record_t;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic [7:0]        byte_in   = 8'h00;
  logic              out_stall = 1'b0;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [DATA_W-1:0] pwdata    = '0;

  logic               in_stall;
  logic               out_valid;
  logic [1:0]         frame_kind;
  logic               data_valid;
  logic [4:0]         cell_count;
  logic [15:0]        cell_min_mv;
  logic [15:0]        cell_max_mv;
  logic [15:0]        cell_avg_mv;
  logic [15:0]        cell_delta_mv;
  logic [19:0]        pack_total_mv;
  logic signed [19:0] pack_current_ma;
  logic [7:0]         state_of_charge;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  // predictor state
  parse_phase_t  scan_phase = PH_SYNC0;
  int            frame_len  = 0;
  int            body_idx   = 0;
  logic [7:0]    cmd_seen   = '0;
  logic [15:0]   sub_seen   = '0;
  logic [7:0]    hold_hi    = '0;
  int            run_sum    = 0;
  int            run_good   = 0;
  int            run_min    = 'hFFFF;
  int            run_max    = 0;
  logic [15:0]   pk_total   = '0;
  logic [15:0]   pk_current = '0;
  logic [7:0]    pk_soc     = '0;
  logic [15:0]   lim_low    = CELL_LOW_RST;
  logic [15:0]   lim_high   = CELL_HIGH_RST;
  logic [4:0]    need_cells = MIN_GOOD_RST;
  frame_record_t record_now = '0;
  frame_record_t pending_records[$];

  int          records_predicted = 0;
  int          bytes_sent        = 0;
  int          mismatches        = 0;
  int          holdoff_request   = 0;
  int          hold_left         = 0;
  int unsigned cycle_count       = 0;
  bit          jitter_on         = 1'b1;

  bms_frame_parser_cell_stats #(
    .MAX_CELL_COUNT    (CELL_SLOTS),
    .FRAME_BUFFER_BYTES(FRAME_BYTES)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .byte_in        (byte_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .frame_kind     (frame_kind),
    .data_valid     (data_valid),
    .cell_count     (cell_count),
    .cell_min_mv    (cell_min_mv),
    .cell_max_mv    (cell_max_mv),
    .cell_avg_mv    (cell_avg_mv),
    .cell_delta_mv  (cell_delta_mv),
    .pack_total_mv  (pack_total_mv),
    .pack_current_ma(pack_current_ma),
    .state_of_charge(state_of_charge),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  function automatic frame_kind_t body_kind();
    if (cmd_seen != CMD_READ) return KIND_UNKNOWN;
    if (sub_seen == SUB_CELLS) return KIND_CELLS;
    if (sub_seen == SUB_PACK) return KIND_PACK;
    return KIND_UNKNOWN;
  endfunction

  task automatic close_frame();
    frame_kind_t   kind;
    int            need;
    int            cur_signed;
    frame_record_t want;
    kind = body_kind();
    if (kind == KIND_CELLS) begin
      need = (need_cells == 0) ? 1 : int'(need_cells);
      if (run_good >= need) begin
        record_now.count     = 5'(run_good);
        record_now.min_mv    = 16'(run_min);
        record_now.max_mv    = 16'(run_max);
        record_now.avg_mv    = 16'(run_sum / run_good);
        record_now.spread_mv = 16'(run_max - run_min);
        record_now.total_mv  = 20'(run_sum);
        record_now.valid     = 1'b1;
      end
    end else if (kind == KIND_PACK && frame_len >= PACK_MIN_LEN) begin
      if (record_now.total_mv == 0) record_now.total_mv = 20'(int'(pk_total) * 10);
      if (frame_len >= CUR_MIN_LEN) begin
        cur_signed = int'($signed(pk_current));
        record_now.current_ma = 20'(cur_signed * 10);
      end
      if (frame_len >= SOC_MIN_LEN) record_now.soc = pk_soc;
    end
    scan_phase = PH_SYNC0;
    want = record_now;
    want.kind = kind;
    pending_records.push_back(want);
    records_predicted++;
  endtask

  // advance the parser model by one accepted byte
  task automatic parse_byte(input logic [7:0] b);
    int mv;
    case (scan_phase)
      PH_SYNC0: begin
        if (b == SYNC0_BYTE) scan_phase = PH_SYNC1;
      end
      PH_SYNC1: begin
        if (b == SYNC1_BYTE) scan_phase = PH_LEN;
        else if (b != SYNC0_BYTE) scan_phase = PH_SYNC0;
      end
      PH_LEN: begin
        frame_len = int'(b);
        if (b < MIN_LEN || int'(b) > FRAME_BYTES - 3) begin
          scan_phase = PH_SYNC0;
        end else begin
          body_idx = 0; cmd_seen = '0; sub_seen = '0; hold_hi = '0;
          run_sum = 0; run_good = 0; run_min = 'hFFFF; run_max = 0;
          pk_total = '0; pk_current = '0; pk_soc = '0;
          scan_phase = PH_BODY;
        end
      end
      default: begin
        case (body_idx)
          POS_CMD:    cmd_seen = b;
          POS_SUB_HI: sub_seen = {b, 8'h00};
          POS_SUB_LO: sub_seen[7:0] = b;
          POS_TOT_HI: pk_total = {b, 8'h00};
          POS_TOT_LO: pk_total[7:0] = b;
          POS_CUR_HI: pk_current = {b, 8'h00};
          POS_CUR_LO: pk_current[7:0] = b;
          POS_SOC:    pk_soc = b;
          default: ;
        endcase
        if (body_idx >= POS_TOT_HI) begin
          if (body_idx % 2 == 1) begin
            hold_hi = b;
          end else if (body_kind() == KIND_CELLS && (body_idx - 4) / 2 < CELL_SLOTS) begin
            mv = int'({hold_hi, b});
            if (mv > lim_low && mv < lim_high) begin
              run_sum += mv;
              if (run_sum > 'hFFFFF) run_sum = 'hFFFFF;
              run_good = (run_good + 1) % 32;
              if (mv < run_min) run_min = mv;
              if (mv > run_max) run_max = mv;
            end
          end
        end
        body_idx++;
        if (body_idx >= frame_len) close_frame();
      end
    endcase
  endtask

  function automatic void note_field(string name, logic [19:0] want, logic [19:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %h, got %h", name, want, got);
    end
  endfunction

  function automatic void check_record();
    frame_record_t want;
    if (pending_records.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("result transaction with nothing pending");
      return;
    end
    want = pending_records.pop_front();
    note_field("frame_kind", 20'(want.kind), 20'(frame_kind));
    note_field("data_valid", 20'(want.valid), 20'(data_valid));
    note_field("cell_count", 20'(want.count), 20'(cell_count));
    note_field("cell_min_mv", 20'(want.min_mv), 20'(cell_min_mv));
    note_field("cell_max_mv", 20'(want.max_mv), 20'(cell_max_mv));
    note_field("cell_avg_mv", 20'(want.avg_mv), 20'(cell_avg_mv));
    note_field("cell_delta_mv", 20'(want.spread_mv), 20'(cell_delta_mv));
    note_field("pack_total_mv", want.total_mv, pack_total_mv);
    note_field("pack_current_ma", want.current_ma, pack_current_ma);
    note_field("state_of_charge", 20'(want.soc), 20'(state_of_charge));
  endfunction

  // result side: check each accepted transaction, then choose next cycle's stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) check_record();
    if (holdoff_request > 0) begin
      hold_left = holdoff_request;
      holdoff_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= jitter_on && ($urandom_range(99) < 13);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (jitter_on && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_in  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_byte(b);
    bytes_sent++;
  endtask

  task automatic send_all(input byte_list_t q);
    foreach (q[i]) send_byte(q[i]);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_CELL_LOW:  lim_low = val[15:0];
      REG_CELL_HIGH: lim_high = val[15:0];
      REG_MIN_GOOD:  need_cells = val[4:0];
      default: ;
    endcase
  endtask

  // drain all results, then let the last bytes finish before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_limits(input logic [15:0] lo, input logic [15:0] hi, input logic [4:0] need);
    settle();
    write_reg(REG_CELL_LOW, DATA_W'(lo));
    write_reg(REG_CELL_HIGH, DATA_W'(hi));
    write_reg(REG_MIN_GOOD, DATA_W'(need));
  endtask

  function automatic byte_list_t make_frame(logic [7:0] cmd, logic [15:0] sub, byte_list_t data);
    byte_list_t q;
    q.push_back(SYNC0_BYTE);
    q.push_back(SYNC1_BYTE);
    q.push_back(8'(data.size() + 3));
    q.push_back(cmd);
    q.push_back(sub[15:8]);
    q.push_back(sub[7:0]);
    foreach (data[i]) q.push_back(data[i]);
    return q;
  endfunction

  function automatic void add_mv(ref byte_list_t d, input logic [15:0] mv);
    d.push_back(mv[15:8]);
    d.push_back(mv[7:0]);
  endfunction

  function automatic logic [15:0] pick_mv(bit want_good);
    if (want_good && int'(lim_high) > int'(lim_low) + 1)
      return 16'($urandom_range(int'(lim_high) - 1, int'(lim_low) + 1));
    return 16'($urandom_range(16'hFFFF, 0));
  endfunction

  function automatic byte_list_t cell_body(int n, int bad_pct);
    byte_list_t d;
    for (int i = 0; i < n; i++) add_mv(d, pick_mv($urandom_range(99) >= bad_pct));
    return d;
  endfunction

  function automatic byte_list_t pack_body(logic [15:0] tot, logic [15:0] cur,
                                           logic [7:0] soc, int n);
    byte_list_t d;
    for (int i = 0; i < n; i++) d.push_back(8'($urandom));
    if (n > 0) d[0] = tot[15:8];
    if (n > 1) d[1] = tot[7:0];
    if (n > 12) d[12] = cur[15:8];
    if (n > 13) d[13] = cur[7:0];
    if (n > 22) d[22] = soc;
    return d;
  endfunction

  // sync hunting, repeated sync bytes, rejected lengths, shortest frame
  task automatic test_framing();
    logic [7:0] lead [13] = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h00, 8'hA5, 8'hA5,
                              8'hA5, 8'h5A, 8'h03, 8'h00, 8'h00, 8'h00};
    logic [7:0] bad_len [5] = '{8'd0, 8'd1, 8'd2, 8'd254, 8'd255};
    byte_list_t none;
    foreach (lead[i]) send_byte(lead[i]);
    foreach (bad_len[i]) begin
      send_byte(SYNC0_BYTE);
      send_byte(SYNC1_BYTE);
      send_byte(bad_len[i]);
    end
    send_all(make_frame(CMD_READ, SUB_CELLS, none));
  endtask

  // pack frames across the length gates, total adopted while the record is empty
  task automatic test_pack_frames();
    send_all(make_frame(CMD_READ, SUB_PACK, pack_body(16'h4321, 16'h0000, 8'h00, 2)));
    send_all(make_frame(CMD_READ, SUB_PACK, pack_body(16'h0000, 16'h0000, 8'h00, 3)));
    send_all(make_frame(CMD_READ, SUB_PACK, pack_body(16'h0000, 16'h1234, 8'h00, 13)));
    send_all(make_frame(CMD_READ, SUB_PACK, pack_body(16'hFFFF, 16'h8000, 8'h00, 14)));
    send_all(make_frame(CMD_READ, SUB_PACK, pack_body(16'h0001, 16'hFFFF, 8'h77, 22)));
    send_all(make_frame(CMD_READ, SUB_PACK, pack_body(16'h1234, 16'h7FFF, 8'hFF, 23)));
  endtask

  task automatic test_cell_frames();
    byte_list_t d;
    byte_list_t rest;
    add_mv(d, CELL_LOW_RST);
    add_mv(d, CELL_HIGH_RST);
    add_mv(d, CELL_LOW_RST + 16'd1);
    add_mv(d, CELL_HIGH_RST - 16'd1);
    rest = cell_body(10, 0);
    foreach (rest[i]) d.push_back(rest[i]);
    send_all(make_frame(CMD_READ, SUB_CELLS, d));
    send_all(make_frame(CMD_READ, SUB_CELLS, cell_body(11, 0)));
    // cells past the last slot are ignored
    send_all(make_frame(CMD_READ, SUB_CELLS, cell_body(26, 10)));
    d = cell_body(12, 0);
    d.push_back(8'h0F);
    send_all(make_frame(CMD_READ, SUB_CELLS, d));
    send_all(make_frame(8'h83, SUB_CELLS, cell_body(12, 0)));
    send_all(make_frame(CMD_READ, 16'h1101, cell_body(12, 0)));
    send_all(make_frame(CMD_READ, SUB_PACK, pack_body(16'h2222, 16'h0100, 8'h40, 23)));
  endtask

  // threshold extremes, sum saturation, zero and unreachable good-cell counts
  task automatic test_limits();
    byte_list_t d;
    set_limits(16'd0, 16'hFFFF, 5'd24);
    for (int i = 0; i < 24; i++) add_mv(d, 16'($urandom_range(16'hFFFE, 16'hF000)));
    send_all(make_frame(CMD_READ, SUB_CELLS, d));
    d.delete();
    add_mv(d, 16'h0000);
    add_mv(d, 16'hFFFF);
    for (int i = 0; i < 22; i++) add_mv(d, 16'($urandom_range(16'hFFFE, 1)));
    send_all(make_frame(CMD_READ, SUB_CELLS, d));
    set_limits(16'd0, 16'hFFFF, 5'd0);
    send_all(make_frame(CMD_READ, SUB_CELLS, cell_body(1, 0)));
    set_limits(16'd0, 16'hFFFF, 5'd31);
    send_all(make_frame(CMD_READ, SUB_CELLS, cell_body(24, 0)));
    set_limits(16'hFFFF, 16'd0, 5'd1);
    send_all(make_frame(CMD_READ, SUB_CELLS, cell_body(5, 0)));
  endtask

  task automatic random_burst(output int counted);
    byte_list_t q;
    byte_list_t d;
    int pick;
    pick = $urandom_range(99);
    counted = 0;
    if (pick < 45) begin
      d = cell_body($urandom_range(26), 20);
      if ($urandom_range(3) == 0) d.push_back(8'($urandom));
      q = make_frame(CMD_READ, SUB_CELLS, d);
    end else if (pick < 70) begin
      q = make_frame(CMD_READ, SUB_PACK,
                     pack_body(16'($urandom), 16'($urandom), 8'($urandom), $urandom_range(30)));
    end else if (pick < 78) begin
      if ($urandom_range(1)) q = make_frame(8'($urandom), SUB_CELLS, cell_body($urandom_range(6), 0));
      else q = make_frame(CMD_READ, 16'($urandom), cell_body($urandom_range(6), 0));
    end else begin
      case ($urandom_range(3))
        0: repeat ($urandom_range(6, 1)) q.push_back(8'($urandom));
        1: begin
          q.push_back(SYNC0_BYTE);
          q.push_back(8'($urandom));
        end
        2: begin
          q.push_back(SYNC0_BYTE);
          q.push_back(SYNC1_BYTE);
          q.push_back($urandom_range(1) ? 8'($urandom_range(2)) : 8'($urandom_range(255, 254)));
        end
        default: begin
          q = make_frame(CMD_READ, SUB_CELLS, cell_body(4, 0));
          repeat ($urandom_range(q.size() - 4, 1)) void'(q.pop_back());
        end
      endcase
    end
    if (pick < 78) counted = q.size();
    send_all(q);
  endtask

  task automatic test_random(input logic [15:0] lo, input logic [15:0] hi, input logic [4:0] need,
                             input int min_bytes, input int min_records);
    int counted;
    int frame_bytes;
    int made0;
    set_limits(lo, hi, need);
    frame_bytes = 0;
    made0 = records_predicted;
    while (frame_bytes < min_bytes || records_predicted - made0 < min_records) begin
      random_burst(counted);
      frame_bytes += counted;
    end
  endtask

  // long receiver hold-off while frames keep coming, so the input backs up
  task automatic test_backpressure();
    set_limits(CELL_LOW_RST, CELL_HIGH_RST, 5'd1);
    holdoff_request = 300;
    repeat (5) send_all(make_frame(CMD_READ, SUB_CELLS, cell_body($urandom_range(4, 1), 0)));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_framing();
    test_pack_frames();
    test_cell_frames();
    test_limits();
    test_random(CELL_LOW_RST, CELL_HIGH_RST, MIN_GOOD_RST, 20, 1);
    jitter_on = 1'b0;
    test_random(16'd0, 16'hFFFF, 5'd1, 40, 2);
    jitter_on = 1'b1;
    test_random(16'd3000, 16'd3600, 5'd4, 20, 1);
    test_random(16'($urandom), 16'($urandom), 5'($urandom), 20, 1);
    test_backpressure();
    in_valid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
